[rtl/core/dq_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// Deque package
// Shared widths, request codes and status codes of the double-ended queue.
// ============================================================================
package dq_pkg;

    localparam int DQ_DEPTH  = 32;
    localparam int REQ_W     = 3;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int ENTRIES_W = 7;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_LIST       = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_POP_BACK   = 3'd4
    } req_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

endpackage

[rtl/core/dq_ram.sv]
`timescale 1ns / 1ps
// ============================================================================
// Generic RAM
// One write port and one read port; read data is registered and holds its
// value until the next read.
// ============================================================================
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/dq_addr.sv]
`timescale 1ns / 1ps
// ============================================================================
// Circular address unit
// Adds an offset to the front index and wraps the sum into the store depth.
// ============================================================================
module dq_addr #(
    parameter int DEPTH = 32
) (
    input  logic [$clog2(DEPTH)-1:0] base,
    input  logic [$clog2(DEPTH)-1:0] offset,
    output logic [$clog2(DEPTH)-1:0] addr
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW:0] DEPTH_V = (AW+1)'(DEPTH);

    logic [AW:0] sum_raw;
    logic [AW:0] sum_wrap;

    // Both operands stay below the depth, so one subtract is enough.
    assign sum_raw  = {1'b0, base} + {1'b0, offset};
    assign sum_wrap = (sum_raw >= DEPTH_V) ? (sum_raw - DEPTH_V) : sum_raw;
    assign addr     = sum_wrap[AW-1:0];

endmodule

[rtl/core/double_ended_queue_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// Double-ended queue
// Bounded deque of 32-bit words in a circular RAM with front index and count.
// ============================================================================
// Usage:
// Requests arrive on the s_ group: s_tuser carries the request kind (push
// front, push back, list, pop front, pop back) and s_tdata the word to push.
// Results leave on the m_ group: m_tuser is the status, m_tdata holds the
// value and the entry count after the request, and m_tlast marks the final
// beat of a request. Undefined kinds are taken and produce no beat.
// A push, or a pop or list that finds the queue empty, gives its beat
// in the cycle after acceptance. A pop reads the RAM on acceptance and
// gives its beat from the pop state. A list reads its first entry on
// acceptance, then gives one entry per cycle while m_tready is high.
// These sequences are set by the single registered RAM read port and the one
// circular address adder, which the sequencer shares among all requests.
// s_tready is low while a pop or list is in progress and while a result
// beat waits in the output register; a stalled receiver simply holds the
// block. Reset empties the queue at once; the RAM needs no clearing.
// ============================================================================
module double_ended_queue_top #(
    parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [dq_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] push_value
    input  logic [dq_pkg::REQ_W-1:0]     s_tuser,   // [2:0] req_type
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [dq_pkg::M_TDATA_W-1:0] m_tdata,   // [31:0] out_value, [38:32] entries_held
    output logic [dq_pkg::STATUS_W-1:0]  m_tuser,   // [1:0] status
    output logic                         m_tlast
);

    import dq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_LIST
    } state_t;

    state_t               state_reg;
    logic [AW-1:0]        front_reg;
    logic [CW-1:0]        count_reg;
    logic [AW-1:0]        idx_reg;
    logic                 pop_front_reg;
    logic                 m_tvalid_reg;
    status_t              status_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic [ENTRIES_W-1:0] held_reg;
    logic                 last_reg;

    logic                 accept;
    logic                 out_free;
    logic                 full;
    logic                 empty;
    logic                 list_last;
    logic                 beat_load;
    logic [AW-1:0]        offset;
    logic [AW-1:0]        slot_addr;
    logic                 ram_we;
    logic                 ram_re;
    logic [VALUE_W-1:0]   ram_rdata;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign list_last = (CW'(idx_reg) == (count_reg - CW'(1)));

    // Offset into the circular store for the shared address unit.
    always_comb
    begin
        offset = '0;
        case (state_reg)
            ST_IDLE:
            begin
                case (s_tuser)
                    REQ_PUSH_FRONT: offset = AW'(DEPTH - 1);
                    REQ_PUSH_BACK:  offset = count_reg[AW-1:0];
                    REQ_POP_BACK:   offset = AW'(count_reg - CW'(1));
                    default:        offset = '0;
                endcase
            end
            ST_POP:  offset = AW'(1);
            ST_LIST: offset = idx_reg + AW'(1);
            default: offset = '0;
        endcase
    end

    dq_addr #(
        .DEPTH (DEPTH)
    ) u_addr (
        .base   (front_reg),
        .offset (offset),
        .addr   (slot_addr)
    );

    always_comb
    begin
        ram_we = 1'b0;
        ram_re = 1'b0;
        if (state_reg == ST_IDLE && accept)
        begin
            case (s_tuser)
                REQ_PUSH_FRONT, REQ_PUSH_BACK:           ram_we = !full;
                REQ_LIST, REQ_POP_FRONT, REQ_POP_BACK:   ram_re = !empty;
                default:                                 ram_re = 1'b0;
            endcase
        end
        else if (state_reg == ST_LIST && out_free && !list_last)
        begin
            ram_re = 1'b1;
        end
    end

    // A new result beat enters the output register this cycle.
    always_comb
    begin
        beat_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        REQ_PUSH_FRONT, REQ_PUSH_BACK:         beat_load = 1'b1;
                        REQ_LIST, REQ_POP_FRONT, REQ_POP_BACK: beat_load = empty;
                        default:                               beat_load = 1'b0;
                    endcase
                end
            end
            ST_POP:  beat_load = out_free;
            ST_LIST: beat_load = out_free;
            default: beat_load = 1'b0;
        endcase
    end

    dq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_addr),
        .wdata (s_tdata[VALUE_W-1:0]),
        .re    (ram_re),
        .raddr (slot_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            pop_front_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            status_reg    <= STAT_OK;
            value_reg     <= '0;
            held_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= beat_load || (m_tvalid_reg && !m_tready);
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (s_tuser)
                            REQ_PUSH_FRONT, REQ_PUSH_BACK:
                            begin
                                value_reg    <= '0;
                                last_reg     <= 1'b1;
                                if (full)
                                begin
                                    status_reg <= STAT_FULL;
                                    held_reg   <= ENTRIES_W'(count_reg);
                                end
                                else
                                begin
                                    status_reg <= STAT_OK;
                                    held_reg   <= ENTRIES_W'(count_reg + CW'(1));
                                    count_reg  <= count_reg + CW'(1);
                                    if (s_tuser == REQ_PUSH_FRONT)
                                    begin
                                        front_reg <= slot_addr;
                                    end
                                end
                            end
                            REQ_LIST, REQ_POP_FRONT, REQ_POP_BACK:
                            begin
                                if (empty)
                                begin
                                    status_reg   <= STAT_EMPTY;
                                    value_reg    <= '0;
                                    held_reg     <= '0;
                                    last_reg     <= 1'b1;
                                end
                                else if (s_tuser == REQ_LIST)
                                begin
                                    idx_reg   <= '0;
                                    state_reg <= ST_LIST;
                                end
                                else
                                begin
                                    count_reg     <= count_reg - CW'(1);
                                    pop_front_reg <= (s_tuser == REQ_POP_FRONT);
                                    state_reg     <= ST_POP;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_POP:
                begin
                    if (out_free)
                    begin
                        status_reg   <= STAT_OK;
                        value_reg    <= ram_rdata;
                        held_reg     <= ENTRIES_W'(count_reg);
                        last_reg     <= 1'b1;
                        // The front moves only after its word has been read.
                        if (pop_front_reg)
                        begin
                            front_reg <= slot_addr;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_LIST:
                begin
                    if (out_free)
                    begin
                        status_reg   <= STAT_OK;
                        value_reg    <= ram_rdata;
                        held_reg     <= ENTRIES_W'(count_reg);
                        last_reg     <= list_last;
                        if (list_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + AW'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - VALUE_W - ENTRIES_W){1'b0}}, held_reg, value_reg};
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

    // The entry count never passes the store depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    // A list is only walked over a queue that holds entries.
    a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LIST) |-> (count_reg != '0))
        else $error("list walk over an empty queue");

    // A pop from a nonempty queue removes exactly one entry.
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == REQ_POP_FRONT || s_tuser == REQ_POP_BACK) && !empty)
        |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("pop did not remove one entry");

    // Nothing is written to the store while a full push is dropped.
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && full) |-> !ram_we)
        else $error("write into a full queue");

endmodule
